### rtl/core/lowest_free_gate_allocator_macros.svh
// Assertion macros used by the checker file of the gate allocator.
`ifndef LOWEST_FREE_GATE_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_GATE_ALLOCATOR_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define LFGA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define LFGA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  `LFGA_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

`endif

### rtl/core/lfga_pkg.sv
// Shared constants, types and helper functions of the gate allocator.
package lfga_pkg;

  localparam int GATES      = 64;
  localparam int COUNT_BITS = 17;

  localparam int IDX_W     = (GATES > 1) ? $clog2(GATES) : 1;
  localparam int SLOTS     = 1 << IDX_W;
  localparam int CTR_W     = IDX_W + 1;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 * SLOTS;
  localparam int SUM_W     = COUNT_BITS + 1;

  localparam int TIME_W    = 32;
  localparam int CMD_W     = 2;
  localparam int TOTAL_W   = 7;
  localparam int RES_IDX_W = 6;
  localparam int BEST_W    = 18;

  localparam logic [TOTAL_W-1:0]    TOTAL_RESET = 7'd64;
  localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;
  localparam logic [BEST_W-1:0]     BEST_MAX    = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_PRE1,
    ST_SPLIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_SCAN,
    DP_PRE1,
    DP_SPLIT
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
    logic   issue;
    logic   rewind;
    logic   clear_use;
    logic   emit;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic hit;
    logic miss_last;
    logic issue_end;
    logic pend;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [TIME_W-1:0]     release_time;
    logic [COUNT_BITS-1:0] use_count;
  } entry_t;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [BEST_W-1:0] sat_best(input logic [SUM_W-1:0] s);
    logic [BEST_W-1:0] r;
    if (64'(s) > 64'(BEST_MAX)) begin
      r = BEST_MAX;
    end else begin
      r = BEST_W'(s);
    end
    return r;
  endfunction

endpackage

### rtl/core/lfga_channels.sv
// Handshake channel interfaces of the gate allocator: request, result and configuration.
interface lfga_in_if;
  import lfga_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic              pool;
  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] departure;
  modport source (output valid, cmd, pool, arrival, departure, input ready);
  modport sink   (input valid, cmd, pool, arrival, departure, output ready);
endinterface

interface lfga_out_if;
  import lfga_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [RES_IDX_W-1:0] resource_index;
  logic [BEST_W-1:0]    best_total;
  modport source (output valid, accepted, resource_index, best_total, input ready);
  modport sink   (input valid, accepted, resource_index, best_total, output ready);
endinterface

interface lfga_cfg_if;
  import lfga_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_gates;
  modport source (output valid, total_gates, input ready);
  modport sink   (input valid, total_gates, output ready);
endinterface

### rtl/core/lowest_free_gate_allocator.sv
// Top level of the lowest-free gate allocator with best-split report.
//
//   channel  dir  handshake    payload
//   in_i     in   valid/ready  cmd, pool, arrival, departure
//   res_o    out  valid/ready  accepted, resource_index, best_total
//   cfg_i    in   valid/ready  total_gates (always ready)
//
// One request at a time; every request yields exactly one result.
// Allocate: the entry memory's single read port walks the pool one entry per cycle,
//   and the walk stops at the lowest free entry, which is granted; with no free
//   entry among all GATES entries the request is rejected.
// Report: a walk of n pool-1 entries, then one of n + 1 pool-0 entries, through the same port.
// Clear and no-op walk no entries. Reset clears the occupancy flags at once: no sweep.
// A new request is taken while a result waits in the output register.
module lowest_free_gate_allocator (
  input logic        clk_i,
  input logic        rst_ni,
  lfga_in_if.sink    in_i,
  lfga_out_if.source res_o,
  lfga_cfg_if.sink   cfg_i
);
  import lfga_pkg::*;

  ctl_t ctl;
  sts_t sts;

  lfga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  lfga_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_cmd_i       (in_i.cmd),
    .in_pool_i      (in_i.pool),
    .in_arrival_i   (in_i.arrival),
    .in_departure_i (in_i.departure),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_ready_o    (cfg_i.ready),
    .cfg_total_i    (cfg_i.total_gates),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .out_accepted_o (res_o.accepted),
    .out_index_o    (res_o.resource_index),
    .out_best_o     (res_o.best_total)
  );

endmodule

### rtl/core/lfga_ctrl.sv
// Sequencing state machine of the gate allocator.
module lfga_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lfga_pkg::sts_t sts_i,
  output lfga_pkg::ctl_t ctl_o
);
  import lfga_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts_i.cmd)
          CMD_ALLOC:  state_d = ST_SCAN;
          CMD_REPORT: state_d = ST_PRE1;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.miss_last) state_d = ST_DONE;
      end
      ST_PRE1: begin
        if (sts_i.issue_end && !sts_i.pend) state_d = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (sts_i.issue_end && !sts_i.pend) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    ctl_o.op   = DP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      ST_DISPATCH: begin
        ctl_o.clear_use = (sts_i.cmd == CMD_CLEAR);
      end
      ST_SCAN: begin
        ctl_o.op    = DP_SCAN;
        ctl_o.issue = !sts_i.issue_end && !sts_i.hit;
      end
      ST_PRE1: begin
        ctl_o.op     = DP_PRE1;
        ctl_o.issue  = !sts_i.issue_end;
        // restart the walk for the split pass once pool 1 has drained
        ctl_o.rewind = sts_i.issue_end && !sts_i.pend;
      end
      ST_SPLIT: begin
        ctl_o.op    = DP_SPLIT;
        ctl_o.issue = !sts_i.issue_end;
      end
      ST_DONE: begin
        ctl_o.emit = sts_i.out_free;
      end
      default: begin
        ctl_o.op = DP_NONE;
      end
    endcase
  end

endmodule

### rtl/core/lfga_dp.sv
// Datapath of the gate allocator: entry memory, prefix buffer, scan and split arithmetic.
module lfga_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lfga_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic                           in_pool_i,
  input  logic [lfga_pkg::TIME_W-1:0]    in_arrival_i,
  input  logic [lfga_pkg::TIME_W-1:0]    in_departure_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lfga_pkg::TOTAL_W-1:0]   cfg_total_i,
  input  lfga_pkg::ctl_t                 ctl_i,
  output lfga_pkg::sts_t                 sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           out_accepted_o,
  output logic [lfga_pkg::RES_IDX_W-1:0] out_index_o,
  output logic [lfga_pkg::BEST_W-1:0]    out_best_o
);
  import lfga_pkg::*;

  // storage
  entry_t                ent_mem  [MEM_DEPTH];
  logic [COUNT_BITS-1:0] pbuf_mem [SLOTS];
  logic [SLOTS-1:0]      in_use_q [2];

  // held item
  cmd_e              cmd_q;
  logic              pool_q;
  logic [TIME_W-1:0] arr_q;
  logic [TIME_W-1:0] dep_q;
  logic [CTR_W-1:0]  n_q;
  logic [CTR_W-1:0]  n_d;
  logic [TOTAL_W-1:0] total_q;

  // walk and read pipeline
  logic [CTR_W-1:0]      idx_q;
  logic [CTR_W-1:0]      rd_idx_q;
  logic                  rd_pend_q;
  entry_t                rd_q;
  logic [COUNT_BITS-1:0] pbuf_q;
  logic                  pzero_q;

  // accumulators and result
  logic [COUNT_BITS-1:0] acc_q;
  logic [SUM_W-1:0]      best_q;
  logic                  res_acc_q;
  logic [RES_IDX_W-1:0]  res_idx_q;

  logic                 out_vld_q;
  logic                 out_acc_q;
  logic [RES_IDX_W-1:0] out_idx_q;
  logic [BEST_W-1:0]    out_best_q;

  logic                  cur_pool;
  logic [IDX_W-1:0]      rd_sel;
  logic                  ent_used;
  logic                  free;
  logic                  hit;
  logic                  issue_end;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [COUNT_BITS-1:0] acc_sum;
  logic [CTR_W-1:0]      k;
  logic [CTR_W-1:0]      k_m1;
  logic [SUM_W-1:0]      split_sum;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  entry_t                wr_ent;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (ctl_i.op)
      DP_SCAN: cur_pool = pool_q;
      DP_PRE1: cur_pool = 1'b1;
      default: cur_pool = 1'b0;
    endcase
  end

  assign rd_sel   = rd_idx_q[IDX_W-1:0];
  assign ent_used = in_use_q[cur_pool][rd_sel];
  assign free     = !ent_used || (rd_q.release_time < arr_q);
  assign hit      = (ctl_i.op == DP_SCAN) && rd_pend_q && free;
  assign cnt_eff  = ent_used ? rd_q.use_count : '0;
  assign acc_sum  = sat_add(acc_q, cnt_eff);

  // pool 1 prefix at n - i sits at buffer slot n - i - 1; n - i of zero reads as nought
  assign k         = n_q - idx_q;
  assign k_m1      = k - CTR_W'(1);
  assign split_sum = SUM_W'(acc_q) + SUM_W'(pzero_q ? '0 : pbuf_q);

  always_comb begin
    case (ctl_i.op)
      DP_SCAN:  issue_end = (idx_q == CTR_W'(GATES));
      DP_PRE1:  issue_end = (idx_q >= n_q);
      DP_SPLIT: issue_end = (idx_q > n_q);
      default:  issue_end = 1'b1;
    endcase
  end

  always_comb begin
    if (int'(total_q) > GATES) begin
      n_d = CTR_W'(GATES);
    end else begin
      n_d = CTR_W'(total_q);
    end
  end

  assign rd_addr             = {cur_pool, idx_q[IDX_W-1:0]};
  assign wr_addr             = {pool_q, rd_sel};
  assign wr_ent.release_time = dep_q;
  assign wr_ent.use_count    = ent_used ? sat_add(rd_q.use_count, COUNT_BITS'(1))
                                        : COUNT_BITS'(1);

  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.hit       = hit;
    sts_o.miss_last = (ctl_i.op == DP_SCAN) && rd_pend_q && !free &&
                      (rd_idx_q == CTR_W'(GATES - 1));
    sts_o.issue_end = issue_end;
    sts_o.pend      = rd_pend_q;
    sts_o.out_free  = !out_vld_q || out_ready_i;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (hit) ent_mem[wr_addr] <= wr_ent;
    if (ctl_i.issue) rd_q <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if ((ctl_i.op == DP_PRE1) && rd_pend_q) pbuf_mem[rd_sel] <= acc_sum;
    if ((ctl_i.op == DP_SPLIT) && ctl_i.issue) pbuf_q <= pbuf_mem[k_m1[IDX_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_e'(in_cmd_i);
      pool_q <= in_pool_i;
      arr_q  <= in_arrival_i;
      dep_q  <= in_departure_i;
      n_q    <= n_d;
    end
    if (ctl_i.issue) begin
      rd_idx_q <= idx_q;
      pzero_q  <= (k == '0);
    end
    if (ctl_i.emit) begin
      out_acc_q  <= res_acc_q;
      out_idx_q  <= res_idx_q;
      out_best_q <= sat_best(best_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RESET;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      acc_q       <= '0;
      best_q      <= '0;
      res_acc_q   <= 1'b0;
      res_idx_q   <= '0;
      in_use_q[0] <= '0;
      in_use_q[1] <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) total_q <= cfg_total_i;

      rd_pend_q <= ctl_i.issue;

      if (ctl_i.load || ctl_i.rewind) begin
        idx_q <= '0;
      end else if (ctl_i.issue) begin
        idx_q <= idx_q + CTR_W'(1);
      end

      if (ctl_i.load || ctl_i.rewind) begin
        acc_q <= '0;
      end else if (rd_pend_q && ((ctl_i.op == DP_PRE1) || (ctl_i.op == DP_SPLIT))) begin
        acc_q <= acc_sum;
      end

      if (ctl_i.load) begin
        best_q <= '0;
      end else if (rd_pend_q && (ctl_i.op == DP_SPLIT) && (split_sum > best_q)) begin
        best_q <= split_sum;
      end

      if (ctl_i.load) begin
        res_acc_q <= 1'b0;
        res_idx_q <= '0;
      end else if (hit) begin
        res_acc_q <= 1'b1;
        res_idx_q <= RES_IDX_W'(rd_idx_q);
      end

      if (ctl_i.clear_use) begin
        in_use_q[0] <= '0;
        in_use_q[1] <= '0;
      end else if (hit) begin
        in_use_q[pool_q][rd_sel] <= 1'b1;
      end

      if (ctl_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_accepted_o = out_acc_q;
  assign out_index_o    = out_idx_q;
  assign out_best_o     = out_best_q;

endmodule

### rtl/core/lfga_checker.sv
// Port-level checker of the gate allocator and its bind to the top level.
`include "lowest_free_gate_allocator_macros.svh"

module lfga_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic                           res_accepted_i,
  input logic [lfga_pkg::RES_IDX_W-1:0] res_index_i,
  input logic [lfga_pkg::BEST_W-1:0]    res_best_i
);
  import lfga_pkg::*;

  // a rejected or non-allocate result carries index nought
  `LFGA_ASSERT_IMP(a_idx_zero_unless_granted, clk_i, rst_ni, res_valid_i && !res_accepted_i, res_index_i == '0, "index set on a result without a grant")

  // a grant never carries a split total
  `LFGA_ASSERT_IMP(a_no_total_on_grant, clk_i, rst_ni, res_valid_i && res_accepted_i, res_best_i == '0, "split total set on a granted allocation")

  // drop ready after a request transfer: one request in flight
  `LFGA_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "request taken while another is in flight")

  // hold a stalled result
  `LFGA_ASSERT(a_result_held, clk_i, rst_ni, (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_accepted_i) && $stable(res_index_i) && $stable(res_best_i)), "stalled result changed")

endmodule

bind lowest_free_gate_allocator lfga_checker u_lfga_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_accepted_i (res_o.accepted),
  .res_index_i    (res_o.resource_index),
  .res_best_i     (res_o.best_total)
);
